// File: rtl/core/kmg_pkg.sv
package kmg_pkg;

  // matrix geometry
  localparam int unsigned LINES = 10;
  localparam int unsigned COLS  = 8;
  localparam int unsigned ROW_W = (LINES > 1) ? $clog2(LINES) : 1;

  localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(LINES - 1);
  localparam logic [ROW_W-1:0] LAST_OUTER = ROW_W'(LINES - 2);
  localparam logic [7:0]       LINES_B    = 8'(LINES);
  localparam logic [7:0]       COLS_B     = 8'(COLS);
  localparam logic [7:0]       ALL_UP     = 8'hFF;

  // stream word widths
  localparam int unsigned IN_W  = 24;
  localparam int unsigned OUT_W = 24;

  // item kinds carried on tuser
  localparam logic KIND_KEY = 1'b0;
  localparam logic KIND_SEL = 1'b1;

  // ghost marks for one pair of rows
  typedef struct packed {
    logic [COLS-1:0] mark_a;  // columns to mark in the lower row of the pair
    logic [COLS-1:0] mark_b;  // columns to mark in the upper row of the pair
  } kmg_marks_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_UPD  = 7'b0000010,
    ST_ARD  = 7'b0000100,
    ST_ACAP = 7'b0001000,
    ST_PAIR = 7'b0010000,
    ST_SRD  = 7'b0100000,
    ST_SCAP = 7'b1000000
  } kmg_state_e;

endpackage

// File: rtl/core/kmg_ram.sv
module kmg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/kmg_ghost_unit.sv
module kmg_ghost_unit
  import kmg_pkg::*;
(
  input  logic [COLS-1:0] a_i,
  input  logic [COLS-1:0] b_i,
  output kmg_marks_t      marks_o
);

  logic [COLS-1:0] common;
  logic [COLS-1:0] other;

  // a column is marked when the other row presses it and some other
  // column is pressed in both rows
  always_comb begin
    common = ~a_i & ~b_i;
    for (int x = 0; x < COLS; x++) begin
      other[x] = |(common & ~(COLS'(1) << x));
    end
    marks_o.mark_a = ~b_i & other;
    marks_o.mark_b = ~a_i & other;
  end

endmodule

// File: rtl/core/keyboard_matrix_with_ghosting_core.sv
// keyboard matrix with ghosting, LINES rows by 8 columns, active low
//
// input stream: tuser is the item kind (0 key event, 1 select line),
// tdata carries line, column and press flag. every accepted word gives
// exactly one output word with the selected row (matrix AND clash map,
// 0xFF for a line out of range), the changed flag and the selected line.
//
// a select event or an ignored key event goes from accept through the
// SRD and SCAP states to the output word. a valid key event updates the
// matrix and rebuilds the clash map by sweeping every pair of rows
// through one shared ghost unit, reading the matrix RAM one row a
// cycle, and then goes through SRD and SCAP. the block takes one word
// at a time and is ready only when idle.
//
// reset: no keys pressed, no ghosts, line 0 selected; valid bits stand
// for the matrix RAM, so no clearing pass is needed.
// a stalled receiver holds the output register; a finished item waits
// for it before the next word is taken.
module keyboard_matrix_with_ghosting_core
  import kmg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // line[7:0], bit_req[15:8], down[16], zeros
  input  logic             s_axis_tuser,   // kind
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata    // read_data[7:0], changed[8], current_line[16:9]
);

  kmg_state_e state_q, state_d;

  // latched item
  logic [ROW_W-1:0] line_q;
  logic [2:0]       bit_q;
  logic             down_q;
  logic             changed_q;
  logic [7:0]       sel_q;

  // sweep counters and the held lower row
  logic [ROW_W-1:0] r0_q;
  logic [ROW_W-1:0] r1_q;
  logic [COLS-1:0]  a_q;

  // matrix RAM valid bits and clash map flops
  logic             valid_q [LINES];
  logic             rd_valid_q;
  logic [COLS-1:0]  clash_q [LINES];

  // output register
  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  // RAM port
  logic             ram_we;
  logic [ROW_W-1:0] ram_waddr;
  logic [COLS-1:0]  ram_wdata;
  logic             ram_re;
  logic [ROW_W-1:0] ram_raddr;
  logic [COLS-1:0]  ram_rdata;

  logic             accept;
  logic             key_ok;
  logic             sel_ok;
  logic             out_free;
  logic [COLS-1:0]  row_rd;
  logic [COLS-1:0]  new_row;
  logic [COLS-1:0]  bit_mask;
  logic [COLS-1:0]  sel_clash;
  logic [COLS-1:0]  read_data;
  kmg_marks_t       marks;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign key_ok        = (s_axis_tdata[7:0] < LINES_B) && (s_axis_tdata[15:8] < COLS_B);
  assign sel_ok        = (sel_q < LINES_B);
  assign out_free      = !out_valid_q || m_axis_tready;

  // a row never written reads as all keys up
  assign row_rd   = rd_valid_q ? ram_rdata : ALL_UP;
  assign bit_mask = COLS'(1) << bit_q;
  assign new_row  = down_q ? (row_rd & ~bit_mask) : (row_rd | bit_mask);

  always_comb begin
    sel_clash = ALL_UP;
    for (int i = 0; i < LINES; i++) begin
      if (ROW_W'(i) == sel_q[ROW_W-1:0]) begin
        sel_clash = clash_q[i];
      end
    end
  end

  assign read_data = sel_ok ? (row_rd & sel_clash) : ALL_UP;

  kmg_ram #(
    .WIDTH (COLS),
    .DEPTH (LINES)
  ) u_matrix (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  kmg_ghost_unit u_ghost (
    .a_i     (a_q),
    .b_i     (row_rd),
    .marks_o (marks)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_waddr = line_q;
    ram_wdata = new_row;
    ram_re    = 1'b0;
    ram_raddr = r0_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == KIND_KEY && key_ok) begin
            ram_re    = 1'b1;
            ram_raddr = s_axis_tdata[ROW_W-1:0];
            state_d   = ST_UPD;
          end else begin
            state_d = ST_SRD;
          end
        end
      end
      ST_UPD: begin
        ram_we  = 1'b1;
        state_d = ST_ARD;
      end
      ST_ARD: begin
        ram_re  = 1'b1;
        state_d = ST_ACAP;
      end
      ST_ACAP: begin
        ram_re    = 1'b1;
        ram_raddr = r1_q;
        state_d   = ST_PAIR;
      end
      ST_PAIR: begin
        if (r1_q != LAST_ROW) begin
          ram_re    = 1'b1;
          ram_raddr = r1_q + ROW_W'(1);
        end else if (r0_q != LAST_OUTER) begin
          state_d = ST_ARD;
        end else begin
          state_d = ST_SRD;
        end
      end
      ST_SRD: begin
        ram_re    = sel_ok;
        ram_raddr = sel_q[ROW_W-1:0];
        state_d   = ST_SCAP;
      end
      ST_SCAP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      changed_q   <= 1'b0;
      sel_q       <= 8'd0;
      r0_q        <= '0;
      r1_q        <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < LINES; i++) begin
        valid_q[i] <= 1'b0;
        clash_q[i] <= ALL_UP;
      end
    end else begin
      state_q <= state_d;

      // valid bit travels with the registered RAM read
      if (ram_re) begin
        rd_valid_q <= valid_q[ram_raddr];
      end

      if (accept) begin
        changed_q <= 1'b0;
        if (s_axis_tuser == KIND_SEL) begin
          sel_q <= s_axis_tdata[7:0];
        end
      end

      if (state_q == ST_UPD) begin
        changed_q <= (new_row != row_rd);
        r0_q      <= '0;
        for (int i = 0; i < LINES; i++) begin
          clash_q[i] <= ALL_UP;
          if (ROW_W'(i) == line_q) begin
            valid_q[i] <= 1'b1;
          end
        end
      end

      if (state_q == ST_ARD) begin
        r1_q <= r0_q + ROW_W'(1);
      end

      // fold the pair's ghost marks into both rows of the clash map
      if (state_q == ST_PAIR) begin
        for (int i = 0; i < LINES; i++) begin
          if (ROW_W'(i) == r0_q) begin
            clash_q[i] <= clash_q[i] & ~marks.mark_a;
          end
          if (ROW_W'(i) == r1_q) begin
            clash_q[i] <= clash_q[i] & ~marks.mark_b;
          end
        end
        if (r1_q != LAST_ROW) begin
          r1_q <= r1_q + ROW_W'(1);
        end else begin
          r0_q <= r0_q + ROW_W'(1);
        end
      end

      if (state_q == ST_SCAP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_q <= s_axis_tdata[ROW_W-1:0];
      bit_q  <= s_axis_tdata[10:8];
      down_q <= s_axis_tdata[16];
    end
    if (state_q == ST_ACAP) begin
      a_q <= row_rd;
    end
    if (state_q == ST_SCAP && out_free) begin
      out_data_q <= {7'd0, sel_q, changed_q, read_data};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
